// ----- hdl/stt_pkg.sv -----
// Shared types and character constants for the script text tokenizer.
`timescale 1ns / 1ps

package stt_pkg;

    // Scanner modes, kept in the mode register between text bytes.
    typedef enum logic [2:0] {
        MODE_SKIP    = 3'd0,
        MODE_SLASH   = 3'd1,
        MODE_COMMENT = 3'd2,
        MODE_QUOTE   = 3'd3,
        MODE_WORD    = 3'd4
    } t_mode;

    // Kind of a result beat.
    typedef enum logic [1:0] {
        KIND_WORD  = 2'd0,
        KIND_QUOTE = 2'd1,
        KIND_END   = 2'd2
    } t_kind;

    // Sequencer states of the top level.
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SEND = 2'd1,
        ST_MARK = 2'd2
    } t_state;

    // What one text byte does to the scanner.
    typedef struct packed {
        t_mode mode;      // next mode
        logic  clr_len;   // token starts over before any store
        logic  store;     // byte goes into the token memory
        logic  emit;      // the open token is finished
        t_kind kind;      // kind of the finished token
        logic  end_text;  // end of text marker follows
    } t_scan_act;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;

endpackage

// ----- hdl/script_text_tokenizer.sv -----
// Top level of the script text tokenizer: byte stream in, token beats out.
`timescale 1ns / 1ps

// Text enters on the s_axis channel, one byte per beat; byte 0 ends the text.
// Tokens leave on the m_axis channel as runs of beats, tlast on the final beat
// of each run. tdata carries the token byte and a byte-valid flag; tuser gives
// the kind (word, quoted string, end of text). An empty token, a word that hit
// the capacity, and the end of text marker are single beats with byte-valid 0.
// The cfg channel writes the one-bit high-bytes-are-space register; it is
// always ready and should only be written while the block is idle.
// A byte that finishes no token does not hold the input. A byte that finishes
// a token holds the input while the token memory is read out at one entry per
// cycle through its single read port, unless the receiver stalls; an empty
// token or the end marker is a single beat.
// The first beat of a token is read into the memory read register at the edge
// that accepts the closing byte and then loaded into the output register.
// Reset (synchronous, active low) returns the scanner to whitespace skipping
// with an empty token and sets the register to 1. The token memory is not
// cleared. When the receiver stalls, the output register holds its beat and
// the readout waits; the input stays blocked until the readout is done.
module script_text_tokenizer
    import stt_pkg::*;
#(
    parameter int TOKEN_CAPACITY = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Text input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    // Token output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] token_byte, [8] byte_valid, rest zero
    output logic [1:0]  m_axis_tuser,   // [1:0] token_kind
    output logic        m_axis_tlast,   // run_last
    // Configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data      // high_bytes_are_space
);

    localparam int LEN_W  = $clog2(TOKEN_CAPACITY + 1);
    localparam int ADDR_W = $clog2(TOKEN_CAPACITY);
    localparam logic [LEN_W-1:0] CAP = LEN_W'(TOKEN_CAPACITY);

    // Control state
    t_state           r_state,  n_state;
    t_mode            r_mode,   n_mode;
    logic [LEN_W-1:0] r_len,    n_len;
    logic             r_high_space;
    logic [ADDR_W-1:0] r_idx,   n_idx;
    logic [ADDR_W-1:0] r_last_idx, n_last_idx;
    t_kind            r_kind,   n_kind;
    logic             r_end_pend, n_end_pend;

    // Output register
    logic             r_out_valid;
    logic [7:0]       r_out_byte, n_out_byte;
    logic             r_out_bv,   n_out_bv;
    t_kind            r_out_kind, n_out_kind;
    logic             r_out_last, n_out_last;
    logic             out_load;
    logic             out_free;

    // Token memory
    logic [7:0]        r_mem [TOKEN_CAPACITY];
    logic [7:0]        r_rd_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;

    logic             in_beat;
    t_scan_act        act;
    logic [LEN_W-1:0] base_len;
    logic [LEN_W-1:0] tok_n;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    stt_scan_decode u_decode (
        .i_mode       (r_mode),
        .i_byte       (s_axis_tdata),
        .i_high_space (r_high_space),
        .o_act        (act)
    );

    assign base_len = act.clr_len ? '0 : r_len;
    // A word that reached the capacity is given as an empty token.
    assign tok_n = ((act.kind == KIND_WORD) && (r_len >= CAP)) ? '0 : r_len;

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_len      = r_len;
        n_idx      = r_idx;
        n_last_idx = r_last_idx;
        n_kind     = r_kind;
        n_end_pend = r_end_pend;
        rd_en      = 1'b0;
        rd_addr    = r_idx;
        wr_en      = 1'b0;
        wr_addr    = base_len[ADDR_W-1:0];
        out_load   = 1'b0;
        n_out_byte = r_rd_data;
        n_out_bv   = 1'b1;
        n_out_kind = r_kind;
        n_out_last = (r_idx == r_last_idx);
        unique case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    n_mode = act.mode;
                    n_len  = base_len;
                    if (act.store && (base_len < CAP)) begin
                        wr_en = 1'b1;
                        n_len = base_len + LEN_W'(1);
                    end
                    if (act.emit || act.end_text) begin
                        n_len = '0;
                    end
                    if (act.emit) begin
                        n_kind     = act.kind;
                        n_end_pend = act.end_text;
                        if (tok_n == '0) begin
                            n_state = ST_MARK;
                        end else begin
                            // First entry is read now, so it is ready in ST_SEND.
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            n_idx      = '0;
                            n_last_idx = ADDR_W'(tok_n - LEN_W'(1));
                            n_state    = ST_SEND;
                        end
                    end else if (act.end_text) begin
                        n_kind     = KIND_END;
                        n_end_pend = 1'b0;
                        n_state    = ST_MARK;
                    end
                end
            end
            ST_SEND: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (r_idx == r_last_idx) begin
                        if (r_end_pend) begin
                            n_kind     = KIND_END;
                            n_end_pend = 1'b0;
                            n_state    = ST_MARK;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_idx + ADDR_W'(1);
                        n_idx   = r_idx + ADDR_W'(1);
                    end
                end
            end
            ST_MARK: begin
                n_out_byte = '0;
                n_out_bv   = 1'b0;
                n_out_last = 1'b1;
                if (out_free) begin
                    out_load = 1'b1;
                    if (r_end_pend) begin
                        n_kind     = KIND_END;
                        n_end_pend = 1'b0;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_mode       <= MODE_SKIP;
            r_len        <= '0;
            r_idx        <= '0;
            r_last_idx   <= '0;
            r_kind       <= KIND_WORD;
            r_end_pend   <= 1'b0;
            r_high_space <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_mode     <= n_mode;
            r_len      <= n_len;
            r_idx      <= n_idx;
            r_last_idx <= n_last_idx;
            r_kind     <= n_kind;
            r_end_pend <= n_end_pend;
            if (i_cfg_valid) begin
                r_high_space <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_byte <= n_out_byte;
            r_out_bv   <= n_out_bv;
            r_out_kind <= n_out_kind;
            r_out_last <= n_out_last;
        end
    end

    // Token memory with one write port and one read port with registered read data.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= s_axis_tdata;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_bv, r_out_byte};
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

endmodule

// ----- hdl/stt_scan_decode.sv -----
// Per-byte decision logic of the tokenizer: next mode and token actions.
`timescale 1ns / 1ps

module stt_scan_decode
    import stt_pkg::*;
(
    input  t_mode       i_mode,
    input  logic [7:0]  i_byte,
    input  logic        i_high_space,
    output t_scan_act   o_act
);

    logic is_nul;
    logic is_space;
    logic do_word;

    assign is_nul   = (i_byte == CH_NUL);
    assign is_space = (i_byte <= CH_SPACE) || (i_high_space && i_byte[7]);
    // A slash that is not followed by another slash starts an ordinary word.
    assign do_word  = (i_mode == MODE_WORD) ||
                      ((i_mode == MODE_SLASH) && (i_byte != CH_SLASH));

    always_comb begin
        o_act          = '0;
        o_act.mode     = i_mode;
        o_act.kind     = KIND_WORD;
        if (do_word) begin
            o_act.mode = MODE_WORD;
            if (is_nul) begin
                o_act.emit     = 1'b1;
                o_act.end_text = 1'b1;
                o_act.mode     = MODE_SKIP;
            end else if (is_space) begin
                o_act.emit = 1'b1;
                o_act.mode = MODE_SKIP;
            end else begin
                o_act.store = 1'b1;
            end
        end else begin
            unique case (i_mode)
                MODE_SLASH: begin
                    o_act.clr_len = 1'b1;
                    o_act.mode    = MODE_COMMENT;
                end
                MODE_COMMENT: begin
                    if (is_nul) begin
                        o_act.end_text = 1'b1;
                        o_act.mode     = MODE_SKIP;
                    end else if (i_byte == CH_NL) begin
                        o_act.mode = MODE_SKIP;
                    end
                end
                MODE_QUOTE: begin
                    o_act.kind = KIND_QUOTE;
                    if (is_nul) begin
                        o_act.emit     = 1'b1;
                        o_act.end_text = 1'b1;
                        o_act.mode     = MODE_SKIP;
                    end else if (i_byte == CH_QUOTE) begin
                        o_act.emit = 1'b1;
                        o_act.mode = MODE_SKIP;
                    end else begin
                        o_act.store = 1'b1;
                    end
                end
                default: begin
                    o_act.clr_len = 1'b1;
                    o_act.mode    = MODE_SKIP;
                    if (is_nul) begin
                        o_act.end_text = 1'b1;
                    end else if (is_space) begin
                        o_act.mode = MODE_SKIP;
                    end else if (i_byte == CH_QUOTE) begin
                        o_act.mode = MODE_QUOTE;
                    end else begin
                        o_act.store = 1'b1;
                        o_act.mode  = (i_byte == CH_SLASH) ? MODE_SLASH : MODE_WORD;
                    end
                end
            endcase
        end
    end

endmodule
